// ===== rtl/core/gbs_pkg.sv =====
// shared constants and types for the gravity body step core
// used by gbs_div and the core; depends on nothing
package gbs_pkg;

  localparam int MAX_BODIES = 16;
  localparam int IW         = $clog2(MAX_BODIES);
  localparam int JW         = $clog2(MAX_BODIES + 1);
  localparam int REC_W      = 160;

  localparam logic [1:0] CFG_GRAV = 2'd0;
  localparam logic [1:0] CFG_DT   = 2'd1;

  localparam logic [63:0] MAG_CAP = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] Q_ONE   = 64'd65536;

  typedef logic [IW-1:0] addr_t;
  typedef logic [JW-1:0] cnt_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/gbs_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module gbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gbs_div.sv =====
// restoring divider, 64-bit dividend by 33-bit divisor, one bit a cycle
// depends on gbs_pkg for request and response types
module gbs_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbs_pkg::div_req_t req_i,
  output gbs_pkg::div_rsp_t rsp_o
);

  logic [63:0] num_q, num_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] shifted;
  logic        fits;

  always_comb begin
    shifted = {rem_q[32:0], num_q[63]};
    fits    = shifted >= {1'b0, den_q};
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (shifted - {1'b0, den_q}) : shifted;
      num_d = {num_q[62:0], fits};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      den_q <= req_i.den;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ===== rtl/core/gravity_body_step_core.sv =====
// gravity body step core: body table in ram, force sum and euler update
// depends on gbs_pkg, gbs_ram and gbs_div
//
// usage:
//   cfg channel writes grav_constant (index 0) and time_step (index 1);
//   cfg_ready_o is always high. write only while the core is idle.
//   s_axis carries one item: tuser is the mode (0 load, 1 step).
//   a load writes the slot and gives no result.
//   a step reads the named body, then walks every slot; each other valid
//   body runs a square root and four divisions on one shared divider
//   (three when the pull clips after the first division); a coincident
//   body skips the square root and divisions. every step also has the self
//   read, last scan, clip, euler update and write-back.
//   the next item is taken the cycle after write-back.
//   a step on an empty or out-of-range slot gives no result.
//   m_axis holds the result in an output register; while it waits the
//   core still takes loads and runs the next step up to write-back, then
//   holds s_axis_tready low until the waiting result is taken.
//   reset clears valid bits and the output valid, and sets both cfg registers to 1.0.
module gravity_body_step_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // body_index, load_x, load_y, load_vx, load_vy, load_mass, zero pad
  input  logic [167:0] s_axis_tdata,
  // mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_index, new_x, new_y, new_vx, new_vy, accel_x, accel_y, zero pad
  output logic [199:0] m_axis_tdata,
  // saturated
  output logic         m_axis_tuser
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SELF  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_LOADJ = 4'd3;
  localparam logic [3:0] S_PREP  = 4'd4;
  localparam logic [3:0] S_SQX   = 4'd5;
  localparam logic [3:0] S_SQY   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_GM    = 4'd8;
  localparam logic [3:0] S_DIVS  = 4'd9;
  localparam logic [3:0] S_DIVW  = 4'd10;
  localparam logic [3:0] S_PROD  = 4'd11;
  localparam logic [3:0] S_CLIP  = 4'd12;
  localparam logic [3:0] S_DT    = 4'd13;
  localparam logic [3:0] S_WB    = 4'd14;

  function automatic logic [32:0] clip56(input logic signed [55:0] v);
    logic [32:0] r;
    if (v > 56'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -56'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  logic [3:0]  state_q, state_d;
  logic [31:0] grav_q, dt_q;
  logic [gbs_pkg::MAX_BODIES-1:0] valid_q;
  gbs_pkg::addr_t idx_q;
  gbs_pkg::cnt_t  j_q;
  logic [1:0]  div_ph_q;
  logic [1:0]  prod_ph_q;
  logic [2:0]  dt_ph_q;
  logic        sat_q;

  logic signed [31:0] self_x_q, self_y_q, self_vx_q, self_vy_q;
  logic [31:0] self_m_q, mass_j_q;
  logic signed [32:0] dx_q, dy_q;
  logic [31:0] hx_q, hy_q;
  logic        shr_q;
  logic [63:0] acc_q, sq_v_q, sq_res_q, sq_bit_q;
  logic [32:0] r_q;
  logic [63:0] q_q;
  logic [46:0] mag_q;
  logic [16:0] ux_q, uy_q;
  logic [63:0] prod_q;
  logic signed [55:0] sx_q, sy_q;
  logic [31:0] ax_q, ay_q, vx_q, vy_q, px_q, py_q;

  logic          m_valid_q;
  logic [199:0]  m_data_q;
  logic          m_user_q;

  logic          ram_we;
  gbs_pkg::addr_t ram_addr;
  logic [gbs_pkg::REC_W-1:0] ram_wdata, ram_rdata;

  gbs_pkg::div_req_t div_req;
  gbs_pkg::div_rsp_t div_rsp;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic        in_fire, out_fire;
  logic [3:0]  in_idx;
  gbs_pkg::addr_t in_addr;
  gbs_pkg::addr_t j_addr;
  logic        in_range;
  logic [31:0] sa, sb;
  logic [63:0] sq_sum;
  logic [63:0] full_p;
  logic [47:0] t_mag;
  logic        t_neg;
  logic signed [55:0] t_s;
  logic [31:0] dt_op, dt_base;
  logic [31:0] dt_abs;
  logic signed [55:0] dt_sum;
  logic [32:0] dt_clip;
  logic [32:0] ax_clip, ay_clip;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_valid_q && m_axis_tready;
  assign in_idx        = s_axis_tdata[3:0];
  assign in_addr       = gbs_pkg::addr_t'(in_idx);
  assign in_range      = (32'(in_idx) < gbs_pkg::MAX_BODIES);
  assign j_addr        = gbs_pkg::addr_t'(j_q);

  assign sa     = shr_q ? {1'b0, hx_q[31:1]} : hx_q;
  assign sb     = shr_q ? {1'b0, hy_q[31:1]} : hy_q;
  assign sq_sum = sq_res_q + sq_bit_q;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQX: begin
        mul_a = sa;
        mul_b = sa;
      end
      S_SQY: begin
        mul_a = sb;
        mul_b = sb;
      end
      S_GM: begin
        mul_a = grav_q;
        mul_b = mass_j_q;
      end
      S_PROD: begin
        mul_a = prod_ph_q[0] ? {17'b0, mag_q[46:32]} : mag_q[31:0];
        mul_b = {15'b0, prod_ph_q[1] ? uy_q : ux_q};
      end
      S_DT: begin
        mul_a = dt_abs;
        mul_b = dt_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // contribution of one axis
  assign full_p = prod_q + {mul_p[31:0], 32'b0};
  assign t_mag  = full_p[63:16];
  assign t_neg  = prod_ph_q[1] ? dy_q[32] : dx_q[32];
  assign t_s    = t_neg ? -$signed({8'b0, t_mag}) : $signed({8'b0, t_mag});

  // euler update operands
  always_comb begin
    unique case (dt_ph_q[2:1])
      2'd0: begin
        dt_op   = ax_q;
        dt_base = self_vx_q;
      end
      2'd1: begin
        dt_op   = ay_q;
        dt_base = self_vy_q;
      end
      2'd2: begin
        dt_op   = vx_q;
        dt_base = self_x_q;
      end
      default: begin
        dt_op   = vy_q;
        dt_base = self_y_q;
      end
    endcase
  end
  assign dt_abs  = dt_op[31] ? (32'd0 - dt_op) : dt_op;
  assign dt_sum  = 56'($signed(dt_base)) + (dt_op[31]
                   ? -$signed({8'b0, prod_q[63:16]}) : $signed({8'b0, prod_q[63:16]}));
  assign dt_clip = clip56(dt_sum);
  assign ax_clip = clip56(sx_q);
  assign ay_clip = clip56(sy_q);

  // divider requests
  always_comb begin
    div_req.start = (state_q == S_DIVS);
    div_req.den   = r_q;
    unique case (div_ph_q)
      2'd0:    div_req.num = acc_q;
      2'd1:    div_req.num = {q_q[47:0], 16'b0};
      2'd2:    div_req.num = {16'b0, hx_q, 16'b0};
      default: div_req.num = {16'b0, hy_q, 16'b0};
    endcase
  end

  // memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = in_addr;
    ram_wdata = s_axis_tdata[163:4];
    if (state_q == S_IDLE) begin
      ram_we = in_fire && !s_axis_tuser && in_range;
    end else if (state_q == S_WB) begin
      ram_addr  = idx_q;
      ram_we    = !m_valid_q;
      ram_wdata = {self_m_q, vy_q, vx_q, py_q, px_q};
    end else begin
      ram_addr = j_addr;
    end
  end

  gbs_ram #(
    .WIDTH (gbs_pkg::REC_W),
    .DEPTH (gbs_pkg::MAX_BODIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  gbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && s_axis_tuser && in_range && valid_q[in_addr]) begin
          state_d = S_SELF;
        end
      end
      S_SELF:  state_d = S_SCAN;
      S_SCAN: begin
        if (32'(j_q) >= gbs_pkg::MAX_BODIES) begin
          state_d = S_CLIP;
        end else if (valid_q[j_addr] && (j_addr != idx_q)) begin
          state_d = S_LOADJ;
        end
      end
      S_LOADJ: state_d = S_PREP;
      S_PREP:  state_d = ((dx_q == '0) && (dy_q == '0)) ? S_SCAN : S_SQX;
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_SQRT;
      S_SQRT:  state_d = (sq_bit_q == 64'd1) ? S_GM : S_SQRT;
      S_GM:    state_d = S_DIVS;
      S_DIVS:  state_d = S_DIVW;
      S_DIVW: begin
        if (div_rsp.done) begin
          state_d = (div_ph_q == 2'd3) ? S_PROD : S_DIVS;
        end
      end
      S_PROD:  state_d = (prod_ph_q == 2'd3) ? S_SCAN : S_PROD;
      S_CLIP:  state_d = S_DT;
      S_DT:    state_d = (dt_ph_q == 3'd7) ? S_WB : S_DT;
      S_WB:    state_d = m_valid_q ? S_WB : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      grav_q    <= 32'd65536;
      dt_q      <= 32'd65536;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_addr_i == gbs_pkg::CFG_GRAV) begin
          grav_q <= cfg_data_i;
        end else if (cfg_addr_i == gbs_pkg::CFG_DT) begin
          dt_q <= cfg_data_i;
        end
      end
      if (ram_we && (state_q == S_IDLE)) begin
        valid_q[in_addr] <= 1'b1;
      end
      if (state_q == S_WB && !m_valid_q) begin
        m_valid_q <= 1'b1;
      end else if (out_fire) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        idx_q <= in_addr;
        sat_q <= 1'b0;
        j_q   <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
      end
      S_SELF: begin
        self_x_q  <= ram_rdata[31:0];
        self_y_q  <= ram_rdata[63:32];
        self_vx_q <= ram_rdata[95:64];
        self_vy_q <= ram_rdata[127:96];
        self_m_q  <= ram_rdata[159:128];
      end
      S_SCAN: begin
        if ((32'(j_q) < gbs_pkg::MAX_BODIES) &&
            !(valid_q[j_addr] && (j_addr != idx_q))) begin
          j_q <= j_q + 1'b1;
        end
      end
      S_LOADJ: begin
        dx_q     <= 33'($signed(ram_rdata[31:0])) - 33'(self_x_q);
        dy_q     <= 33'($signed(ram_rdata[63:32])) - 33'(self_y_q);
        mass_j_q <= ram_rdata[159:128];
      end
      S_PREP: begin
        hx_q  <= dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
        hy_q  <= dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
        shr_q <= (dx_q[32] ? 32'(-dx_q) : dx_q[31:0]) >= 32'h8000_0000 ||
                 (dy_q[32] ? 32'(-dy_q) : dy_q[31:0]) >= 32'h8000_0000;
        if ((dx_q == '0) && (dy_q == '0)) begin
          j_q <= j_q + 1'b1;
        end
      end
      S_SQX: acc_q <= mul_p;
      S_SQY: begin
        sq_v_q   <= acc_q + mul_p;
        sq_res_q <= '0;
        sq_bit_q <= 64'h4000_0000_0000_0000;
      end
      S_SQRT: begin
        if (sq_v_q >= sq_sum) begin
          sq_v_q   <= sq_v_q - sq_sum;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      S_GM: begin
        r_q      <= shr_q ? {sq_res_q[31:0], 1'b0} : {1'b0, sq_res_q[31:0]};
        acc_q    <= mul_p;
        div_ph_q <= 2'd0;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          unique case (div_ph_q)
            2'd0: begin
              if (div_rsp.quot[63:48] != '0) begin
                mag_q    <= gbs_pkg::MAG_CAP[46:0];
                sat_q    <= 1'b1;
                div_ph_q <= 2'd2;
              end else begin
                q_q      <= div_rsp.quot;
                div_ph_q <= 2'd1;
              end
            end
            2'd1: begin
              if (div_rsp.quot > gbs_pkg::MAG_CAP) begin
                mag_q <= gbs_pkg::MAG_CAP[46:0];
                sat_q <= 1'b1;
              end else begin
                mag_q <= div_rsp.quot[46:0];
              end
              div_ph_q <= 2'd2;
            end
            2'd2: begin
              ux_q <= (div_rsp.quot > gbs_pkg::Q_ONE) ? 17'h10000 : div_rsp.quot[16:0];
              div_ph_q <= 2'd3;
            end
            default: begin
              uy_q <= (div_rsp.quot > gbs_pkg::Q_ONE) ? 17'h10000 : div_rsp.quot[16:0];
              prod_ph_q <= 2'd0;
            end
          endcase
        end
      end
      S_PROD: begin
        prod_ph_q <= prod_ph_q + 2'd1;
        if (!prod_ph_q[0]) begin
          prod_q <= mul_p;
        end else if (!prod_ph_q[1]) begin
          sx_q <= sx_q + t_s;
        end else begin
          sy_q <= sy_q + t_s;
          j_q  <= j_q + 1'b1;
        end
      end
      S_CLIP: begin
        ax_q    <= ax_clip[31:0];
        ay_q    <= ay_clip[31:0];
        sat_q   <= sat_q | ax_clip[32] | ay_clip[32];
        dt_ph_q <= 3'd0;
      end
      S_DT: begin
        dt_ph_q <= dt_ph_q + 3'd1;
        if (!dt_ph_q[0]) begin
          prod_q <= mul_p;
        end else begin
          sat_q <= sat_q | dt_clip[32];
          unique case (dt_ph_q[2:1])
            2'd0:    vx_q <= dt_clip[31:0];
            2'd1:    vy_q <= dt_clip[31:0];
            2'd2:    px_q <= dt_clip[31:0];
            default: py_q <= dt_clip[31:0];
          endcase
        end
      end
      S_WB: begin
        if (!m_valid_q) begin
          m_data_q <= {4'b0, ay_q, ax_q, vy_q, vx_q, py_q, px_q, 4'(idx_q)};
          m_user_q <= sat_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_ready_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_rsp.busy)
    else $error("input ready while divider busy");

  a_wb_valid_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> valid_q[idx_q])
    else $error("write-back to empty slot");

  a_result_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_WB)
    else $error("result raised outside write-back");

  a_scan_skips_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOADJ) |-> (j_addr != idx_q))
    else $error("stepped body used as its own source");

endmodule
